// ===== rtl/core/bole_pkg.sv =====
`default_nettype none

package bole_pkg;

    localparam int DATA_W = 32;
    // Cell index / position width, fixed by the 8-bit position field.
    localparam int IDX_W  = 8;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_END   = 3'd4,
        CMD_READ      = 3'd5
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_POS = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_ITEM    = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
        logic [7:0]               position;
    } req_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] item;
        logic                     last;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DROP,
        CELL_ROTATE
    } cell_op_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } cell_ctrl_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_READ
    } fsm_t;

endpackage

`default_nettype wire

// ===== rtl/core/bole_cell.sv =====
`default_nettype none

// One list slot. Decides from its own index which neighbor to take.
module bole_cell #(
    parameter logic [7:0] INDEX = 8'd0
) (
    input  wire logic                          clk,
    input  wire bole_pkg::cell_ctrl_t          ctrl,
    input  wire logic [bole_pkg::DATA_W-1:0]   prev_data,
    input  wire logic [bole_pkg::DATA_W-1:0]   next_data,
    input  wire logic [bole_pkg::DATA_W-1:0]   head_data,
    output logic      [bole_pkg::DATA_W-1:0]   data
);

    logic [bole_pkg::DATA_W-1:0] data_reg;
    logic [bole_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            bole_pkg::CELL_INSERT:
            begin
                if (INDEX == ctrl.idx)
                begin
                    data_next = ctrl.data;
                end
                else if (INDEX > ctrl.idx)
                begin
                    data_next = prev_data;
                end
            end
            bole_pkg::CELL_DROP:
            begin
                data_next = next_data;
            end
            bole_pkg::CELL_ROTATE:
            begin
                // idx is the last occupied slot; it takes the head back
                if (INDEX < ctrl.idx)
                begin
                    data_next = next_data;
                end
                else if (INDEX == ctrl.idx)
                begin
                    data_next = head_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_ordered_list_engine_top.sv =====
`default_nettype none

// Bounded ordered list engine: an ordered list of up to DEPTH signed 32-bit
// values held in a chain of DEPTH cells, slot 0 being the front. A command
// beat is taken at a rising edge with start high and busy low. An insert
// shifts the slots from its position on back by one, a front delete moves
// the whole chain forward by one and an end delete only drops the count;
// their one result beat appears on the cycle after acceptance, and busy
// stays low: a new command may follow on the very next cycle. Read out
// rotates the occupied slots one place per clock, presenting slot 0 each
// time, and gives entry_count beats on consecutive cycles from the cycle
// after acceptance; busy, if raised, falls as the final beat shows. An
// empty read out gives one beat with status empty. Every result beat is
// shown on result for exactly one cycle with result_valid high; there is
// no backpressure, the receiver must take it. result.last marks the final
// beat of each command. Codes six and seven are no-ops that answer ok.
// Slot contents are not reset; only the entry count and control state are.
module bounded_ordered_list_engine_top #(
    parameter int DEPTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire bole_pkg::req_t request,
    output logic                result_valid,
    output bole_pkg::rsp_t      result
);

    // Count must reach DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);
    // Compare width wide enough for both count and the 8-bit position.
    localparam int CMP_W = (CNT_W > bole_pkg::IDX_W) ? CNT_W : bole_pkg::IDX_W;

    bole_pkg::fsm_t       state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic                 valid_reg, valid_next;
    bole_pkg::rsp_t       result_reg, result_next;
    bole_pkg::cell_ctrl_t ctrl;

    logic [bole_pkg::DATA_W-1:0] cell_data [DEPTH];

    logic [CMP_W-1:0] count_wide;
    logic [CMP_W-1:0] last_wide;
    logic [CMP_W-1:0] pos_wide;
    logic             list_full;
    logic             list_empty;

    assign count_wide = CMP_W'(count_reg);
    assign last_wide  = count_wide - CMP_W'(1);
    assign pos_wide   = CMP_W'(request.position);
    assign list_full  = (count_reg == CNT_W'(DEPTH));
    assign list_empty = (count_reg == '0);

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [bole_pkg::DATA_W-1:0] prev_d;
        logic [bole_pkg::DATA_W-1:0] next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = '0;
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_d = '0;
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[i+1];
        end

        bole_cell #(
            .INDEX (8'(i))
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .prev_data (prev_d),
            .next_data (next_d),
            .head_data (cell_data[0]),
            .data      (cell_data[i])
        );
    end

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bole_pkg::FSM_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        valid_next  = 1'b0;
        result_next = '{status: bole_pkg::ST_OK, item: '0, last: 1'b1};
        ctrl        = '{op: bole_pkg::CELL_HOLD, idx: '0, data: request.value};

        unique case (state_reg)
            bole_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    valid_next = 1'b1;
                    unique case (request.command) inside
                        bole_pkg::CMD_INS_FRONT, bole_pkg::CMD_INS_END,
                        bole_pkg::CMD_INS_POS:
                        begin
                            // full takes precedence over a bad position
                            if (list_full)
                            begin
                                result_next.status = bole_pkg::ST_FULL;
                            end
                            else if (request.command == bole_pkg::CMD_INS_POS
                                     && pos_wide > count_wide)
                            begin
                                result_next.status = bole_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                ctrl.op = bole_pkg::CELL_INSERT;
                                if (request.command == bole_pkg::CMD_INS_FRONT)
                                begin
                                    ctrl.idx = '0;
                                end
                                else if (request.command == bole_pkg::CMD_INS_END)
                                begin
                                    ctrl.idx = count_wide[bole_pkg::IDX_W-1:0];
                                end
                                else
                                begin
                                    ctrl.idx = request.position;
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        bole_pkg::CMD_DEL_FRONT:
                        begin
                            if (list_empty)
                            begin
                                result_next.status = bole_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.op    = bole_pkg::CELL_DROP;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        bole_pkg::CMD_DEL_END:
                        begin
                            // tail slot is simply abandoned
                            if (list_empty)
                            begin
                                result_next.status = bole_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        bole_pkg::CMD_READ:
                        begin
                            if (list_empty)
                            begin
                                result_next.status = bole_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // first beat now, chain rotates under it
                                ctrl.op            = bole_pkg::CELL_ROTATE;
                                ctrl.idx           = last_wide[bole_pkg::IDX_W-1:0];
                                result_next.status = bole_pkg::ST_ITEM;
                                result_next.item   = signed'(cell_data[0]);
                                result_next.last   = (count_reg == CNT_W'(1));
                                rem_next           = count_reg - CNT_W'(1);
                                if (count_reg != CNT_W'(1))
                                begin
                                    state_next = bole_pkg::FSM_READ;
                                end
                            end
                        end
                        default:
                        begin
                            // unused codes: answer ok, touch nothing
                            result_next.status = bole_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bole_pkg::FSM_READ:
            begin
                // rem_reg beats still to go; rotation restores order at the end
                valid_next         = 1'b1;
                ctrl.op            = bole_pkg::CELL_ROTATE;
                ctrl.idx           = last_wide[bole_pkg::IDX_W-1:0];
                result_next.status = bole_pkg::ST_ITEM;
                result_next.item   = signed'(cell_data[0]);
                result_next.last   = (rem_reg == CNT_W'(1));
                rem_next           = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = bole_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = bole_pkg::FSM_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg == bole_pkg::FSM_READ);
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bole_checker.sv =====
`default_nettype none

module bole_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           result_valid,
    input wire bole_pkg::rsp_t result
);

    // Every accepted command answers on the next cycle.
    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> result_valid)
        else $error("accepted command gave no result beat");

    // Read out beats are back to back while busy.
    a_busy_streams: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_valid)
        else $error("gap in read out beats");

    // busy only rises right after a command was taken.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) && !$past(busy)))
        else $error("busy rose without an accepted command");

    // Non-item beats are single, final and carry zero.
    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != bole_pkg::ST_ITEM)
            |-> (result.last && result.item == '0))
        else $error("status beat not final or has nonzero item");

    // A non-final beat is always followed by another item beat.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last)
            |=> (result_valid && result.status == bole_pkg::ST_ITEM))
        else $error("read out burst broken");

endmodule

bind bounded_ordered_list_engine_top bole_checker u_bole_checker (.*);

`default_nettype wire
